@@ design/bfj_pkg.sv @@
// ----------------------------------------------------------------------------
// bfj_pkg
// Shared types and constants for the bounded queue with a priority jam slot.
// ----------------------------------------------------------------------------
package bfj_pkg;

   localparam int DEPTH_DEFAULT     = 16;
   localparam int MSG_WIDTH_DEFAULT = 32;

   localparam int MSG_W = 32;   // message port width
   localparam int CNT_W = 5;    // occupancy and capacity width
   localparam int CMD_W = 2;

   localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;
   localparam logic [CNT_W-1:0] CAP_MIN   = 5'd2;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH = 2'd0,
      CMD_POP  = 2'd1,
      CMD_JAM  = 2'd2
   } bfj_cmd_type;

   typedef struct packed {
      logic             valid;
      logic             ok;
      logic             from_fifo;
      logic [CNT_W-1:0] count;
   } bfj_rsp_type;

endpackage

@@ design/bfj_store.sv @@
// ----------------------------------------------------------------------------
// bfj_store
// Message storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bfj_store #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/bfj_ctrl.sv @@
// ----------------------------------------------------------------------------
// bfj_ctrl
// Queue pointers, occupancy, jam slot and capacity register. Decides each
// request combinationally and registers its response flags.
// ----------------------------------------------------------------------------
module bfj_ctrl #(
   parameter int DEPTH   = 16,
   parameter int STORE_W = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [bfj_pkg::CMD_W-1:0]  req_cmd,
   input  logic [STORE_W-1:0]         req_msg,
   input  logic                       csr_write,
   input  logic [bfj_pkg::CNT_W-1:0]  csr_data,
   output logic                       mem_wr_en,
   output logic [$clog2(DEPTH)-1:0]   mem_wr_addr,
   output logic                       mem_rd_en,
   output logic [$clog2(DEPTH)-1:0]   mem_rd_addr,
   output bfj_pkg::bfj_rsp_type       rsp,
   output logic [STORE_W-1:0]         slot_pop
);

   import bfj_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CMP_W = (IDX_W + 1 > CNT_W) ? IDX_W + 1 : CNT_W;
   localparam logic [CNT_W-1:0] DEPTH_LIM = CNT_W'((DEPTH < 31) ? DEPTH : 31);

   logic [CNT_W-1:0]   cap_ff,   cap_in;
   logic [IDX_W-1:0]   rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0]   wr_idx_ff, wr_idx_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [STORE_W-1:0] slot_ff,  slot_in;
   bfj_rsp_type        rsp_ff,   rsp_in;
   logic [STORE_W-1:0] slot_pop_ff, slot_pop_in;

   logic [CNT_W-1:0] cap_used;
   logic [CMP_W-1:0] rd_inc, wr_inc;
   logic             slot_full;

   always_comb begin
      if (cap_ff == '0) begin
         cap_used = '0;
      end else if (cap_ff < CAP_MIN) begin
         cap_used = CAP_MIN;
      end else if (cap_ff > DEPTH_LIM) begin
         cap_used = DEPTH_LIM;
      end else begin
         cap_used = cap_ff;
      end
   end

   assign rd_inc    = CMP_W'(rd_idx_ff) + CMP_W'(1);
   assign wr_inc    = CMP_W'(wr_idx_ff) + CMP_W'(1);
   assign slot_full = (slot_ff != '0);

   always_comb begin
      cap_in         = cap_ff;
      rd_idx_in      = rd_idx_ff;
      wr_idx_in      = wr_idx_ff;
      count_in       = count_ff;
      slot_in        = slot_ff;
      slot_pop_in    = '0;
      rsp_in         = '0;
      mem_wr_en      = 1'b0;
      mem_rd_en      = 1'b0;
      if (csr_write) begin
         cap_in    = csr_data;
         rd_idx_in = '0;
         wr_idx_in = '0;
         count_in  = '0;
         slot_in   = '0;
      end else if (start) begin
         rsp_in.valid = 1'b1;
         case (bfj_cmd_type'(req_cmd))
            CMD_PUSH: begin
               if (cap_used != '0 && count_ff < cap_used) begin
                  mem_wr_en  = 1'b1;
                  wr_idx_in  = (wr_inc >= CMP_W'(cap_used)) ? '0 : IDX_W'(wr_inc);
                  count_in   = count_ff + CNT_W'(1);
                  rsp_in.ok  = 1'b1;
               end
            end
            CMD_POP: begin
               if (cap_used == '0) begin
                  rsp_in.ok = 1'b1;
               end else if (slot_full) begin
                  slot_pop_in = slot_ff;
                  slot_in     = '0;
                  rsp_in.ok   = 1'b1;
               end else if (count_ff != '0) begin
                  mem_rd_en        = 1'b1;
                  rd_idx_in        = (rd_inc >= CMP_W'(cap_used)) ? '0 : IDX_W'(rd_inc);
                  count_in         = count_ff - CNT_W'(1);
                  rsp_in.ok        = 1'b1;
                  rsp_in.from_fifo = 1'b1;
               end
            end
            CMD_JAM: begin
               if (cap_used != '0 && !slot_full) begin
                  slot_in   = req_msg;
                  rsp_in.ok = 1'b1;
               end
            end
            default: begin
            end
         endcase
         rsp_in.count = count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff    <= CAP_RESET;
         rd_idx_ff <= '0;
         wr_idx_ff <= '0;
         count_ff  <= '0;
         slot_ff   <= '0;
         rsp_ff    <= '0;
      end else begin
         cap_ff    <= cap_in;
         rd_idx_ff <= rd_idx_in;
         wr_idx_ff <= wr_idx_in;
         count_ff  <= count_in;
         slot_ff   <= slot_in;
         rsp_ff    <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_pop_ff <= slot_pop_in;
   end

   assign mem_wr_addr = wr_idx_ff;
   assign mem_rd_addr = rd_idx_ff;
   assign rsp         = rsp_ff;
   assign slot_pop    = slot_pop_ff;

endmodule

@@ design/bounded_fifo_with_jam_slot.sv @@
// ----------------------------------------------------------------------------
// bounded_fifo_with_jam_slot
// Bounded circular message queue with a single priority jam slot.
//
//   channel   handshake              payload
//   request   start, busy            req_cmd, req_message
//   response  rsp_valid (strobe)     rsp_ok, rsp_popped_message, rsp_fifo_count
//   csr       csr_valid, csr_ready   csr_queue_capacity
//
// One request per cycle; busy is never raised. The response strobes in the
// cycle after the request is taken, from the controller's response register.
// Reset clears the queue and the jam slot and sets the capacity to 16.
// A capacity write empties the queue and the jam slot.
// The response side cannot stall.
// ----------------------------------------------------------------------------
module bounded_fifo_with_jam_slot #(
   parameter int DEPTH     = bfj_pkg::DEPTH_DEFAULT,
   parameter int MSG_WIDTH = bfj_pkg::MSG_WIDTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [bfj_pkg::CMD_W-1:0] req_cmd,
   input  logic [bfj_pkg::MSG_W-1:0] req_message,
   output logic                      rsp_valid,
   output logic                      rsp_ok,
   output logic [bfj_pkg::MSG_W-1:0] rsp_popped_message,
   output logic [bfj_pkg::CNT_W-1:0] rsp_fifo_count,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [bfj_pkg::CNT_W-1:0] csr_queue_capacity
);

   import bfj_pkg::*;

   localparam int STORE_W = (MSG_WIDTH < MSG_W) ? MSG_WIDTH : MSG_W;
   localparam int IDX_W   = $clog2(DEPTH);

   logic               take;
   logic [STORE_W-1:0] msg;
   logic               mem_wr_en, mem_rd_en;
   logic [IDX_W-1:0]   mem_wr_addr, mem_rd_addr;
   logic [STORE_W-1:0] mem_rd_data;
   logic [STORE_W-1:0] slot_pop;
   logic [STORE_W-1:0] popped;
   bfj_rsp_type        rsp;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign take      = start && !busy;
   assign msg       = req_message[STORE_W-1:0];

   bfj_ctrl #(
      .DEPTH   (DEPTH),
      .STORE_W (STORE_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (take),
      .req_cmd     (req_cmd),
      .req_msg     (msg),
      .csr_write   (csr_valid && csr_ready),
      .csr_data    (csr_queue_capacity),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .rsp         (rsp),
      .slot_pop    (slot_pop)
   );

   bfj_store #(
      .DEPTH (DEPTH),
      .WIDTH (STORE_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (msg),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign popped             = rsp.from_fifo ? mem_rd_data : slot_pop;
   assign rsp_valid          = rsp.valid;
   assign rsp_ok             = rsp.ok;
   assign rsp_popped_message = MSG_W'(popped);
   assign rsp_fifo_count     = rsp.count;

endmodule

@@ dv/bounded_fifo_with_jam_slot_tb.sv @@
// ----------------------------------------------------------------------------
// bounded_fifo_with_jam_slot_tb
// Self-checking regression for the bounded queue with a priority jam slot.
// A tracker class mirrors queue and jam-slot state, predicts the response of
// every accepted request and compares it with the response strobe in order.
// Directed requests cover empty, full, wrap, jam and unused-command cases;
// random phases sweep the capacity register with varying request gaps.
// ----------------------------------------------------------------------------
module bounded_fifo_with_jam_slot_tb;
   import bfj_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int QUEUE_DEPTH  = DEPTH_DEFAULT;
   localparam int REPORT_LIMIT = 10;
   localparam int MAX_GAP      = 20;

   typedef struct packed {
      logic             ok;
      logic [MSG_W-1:0] popped;
      logic [CNT_W-1:0] count;
   } outcome_type;

   class jam_fifo_tracker;
      logic [MSG_W-1:0] store [QUEUE_DEPTH];
      int unsigned      rd_ptr;
      int unsigned      wr_ptr;
      int unsigned      held;
      logic [MSG_W-1:0] jam_word;
      logic [CNT_W-1:0] capacity;
      outcome_type      outcomes_due [$];
      int unsigned      faults;

      function new();
         faults = 0;
         set_capacity(CAP_RESET);
      endfunction

      function void set_capacity(logic [CNT_W-1:0] value);
         capacity = value;
         rd_ptr   = 0;
         wr_ptr   = 0;
         held     = 0;
         jam_word = '0;
      endfunction

      function int unsigned usable();
         int unsigned c;
         c = capacity;
         if (c == 0) return 0;
         if (c < CAP_MIN) c = CAP_MIN;
         if (c > QUEUE_DEPTH) c = QUEUE_DEPTH;
         return c;
      endfunction

      function void flag(string what);
         faults++;
         if (faults <= REPORT_LIMIT) $display("%s", what);
      endfunction

      function void note_request(logic [CMD_W-1:0] cmd, logic [MSG_W-1:0] msg);
         int unsigned lim;
         outcome_type o;
         lim      = usable();
         o.ok     = 1'b0;
         o.popped = '0;
         case (cmd)
            CMD_PUSH: begin
               if (lim != 0 && held < lim) begin
                  store[wr_ptr] = msg;
                  wr_ptr = (wr_ptr + 1 >= lim) ? 0 : wr_ptr + 1;
                  held++;
                  o.ok = 1'b1;
               end
            end
            CMD_POP: begin
               if (lim == 0) begin
                  o.ok = 1'b1;
               end else if (jam_word != '0) begin
                  o.popped = jam_word;
                  jam_word = '0;
                  o.ok     = 1'b1;
               end else if (held != 0) begin
                  o.popped = store[rd_ptr];
                  rd_ptr = (rd_ptr + 1 >= lim) ? 0 : rd_ptr + 1;
                  held--;
                  o.ok = 1'b1;
               end
            end
            CMD_JAM: begin
               if (lim != 0 && jam_word == '0) begin
                  jam_word = msg;
                  o.ok     = 1'b1;
               end
            end
            default: ;
         endcase
         o.count = CNT_W'(held);
         outcomes_due.push_back(o);
      endfunction

      function void check_response(logic ok, logic [MSG_W-1:0] popped,
                                   logic [CNT_W-1:0] count);
         outcome_type want;
         if (outcomes_due.size() == 0) begin
            flag($sformatf("unexpected response: ok=%0b popped=%h count=%0d",
                           ok, popped, count));
            return;
         end
         want = outcomes_due.pop_front();
         if (ok !== want.ok || popped !== want.popped || count !== want.count)
            flag($sformatf({"response mismatch: expected ok=%0b popped=%h count=%0d, ",
                            "got ok=%0b popped=%h count=%0d"},
                           want.ok, want.popped, want.count, ok, popped, count));
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   logic [CMD_W-1:0] req_cmd = CMD_PUSH;
   logic [MSG_W-1:0] req_message = '0;
   logic             rsp_valid;
   logic             rsp_ok;
   logic [MSG_W-1:0] rsp_popped_message;
   logic [CNT_W-1:0] rsp_fifo_count;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [CNT_W-1:0] csr_queue_capacity = CAP_RESET;

   jam_fifo_tracker book;
   int              idle_pct;

   bounded_fifo_with_jam_slot uut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_cmd            (req_cmd),
      .req_message        (req_message),
      .rsp_valid          (rsp_valid),
      .rsp_ok             (rsp_ok),
      .rsp_popped_message (rsp_popped_message),
      .rsp_fifo_count     (rsp_fifo_count),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_queue_capacity (csr_queue_capacity)
   );

   always #1 clock = ~clock;

   // responses first, then the request taken at the same edge
   always @(posedge clock) begin
      if (!reset && book != null) begin
         if (rsp_valid === 1'b1)
            book.check_response(rsp_ok, rsp_popped_message, rsp_fifo_count);
         if (start === 1'b1 && busy === 1'b0)
            book.note_request(req_cmd, req_message);
      end
   end

   task automatic issue(input logic [CMD_W-1:0] cmd, input logic [MSG_W-1:0] msg);
      int gap;
      start       <= 1'b1;
      req_cmd     <= cmd;
      req_message <= msg;
      do @(posedge clock); while (busy !== 1'b0);
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic quiesce();
      start <= 1'b0;
      while (book.outcomes_due.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CNT_W-1:0] value);
      quiesce();
      csr_valid          <= 1'b1;
      csr_queue_capacity <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      book.set_capacity(value);
   endtask

   task automatic run_random(input int count);
      int               bias;
      int               left;
      int               r;
      logic [CMD_W-1:0] cmd;
      logic [MSG_W-1:0] msg;
      left = 0;
      bias = 50;
      repeat (count) begin
         if (left == 0) begin
            left = $urandom_range(15, 6);
            case ($urandom_range(2))
               0:       bias = 85;
               1:       bias = 50;
               default: bias = 15;
            endcase
         end
         left--;
         r = $urandom_range(99);
         if (r < 3)                          cmd = CMD_UNUSED;
         else if (r < 14)                    cmd = CMD_JAM;
         else if ($urandom_range(99) < bias) cmd = CMD_PUSH;
         else                                cmd = CMD_POP;
         case ($urandom_range(15))
            0:       msg = '0;
            1:       msg = '1;
            default: msg = $urandom;
         endcase
         issue(cmd, msg);
      end
   endtask

   initial begin
      int plan [10];
      int idle_plan [4];
      book      = new();
      plan      = '{1, 31, 16, 5, 3, 17, 2, -1, -1, 0};
      idle_plan = '{0, 61, 0, 14};
      idle_pct  = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset capacity: empty pop, zero jam, slot priority, unused command
      issue(CMD_POP, 32'h0000_0000);
      issue(CMD_JAM, 32'h0000_0000);
      issue(CMD_POP, 32'hFFFF_FFFF);
      issue(CMD_PUSH, 32'hFFFF_FFFF);
      issue(CMD_PUSH, 32'h0000_0000);
      issue(CMD_JAM, 32'h8000_0000);
      issue(CMD_JAM, 32'h0000_0001);
      issue(CMD_POP, 32'h0000_0000);
      issue(CMD_POP, 32'h0000_0000);
      issue(CMD_POP, 32'h0000_0000);
      issue(CMD_UNUSED, 32'hFFFF_FFFF);
      issue(CMD_POP, 32'h0000_0000);

      // smallest queue: full and wrap
      write_capacity(5'd2);
      issue(CMD_PUSH, 32'hA5A5_A5A5);
      issue(CMD_PUSH, 32'h5A5A_5A5A);
      issue(CMD_PUSH, 32'h0000_0001);
      issue(CMD_POP, 32'h0000_0000);
      issue(CMD_PUSH, 32'h0000_0003);
      issue(CMD_POP, 32'h0000_0000);
      issue(CMD_POP, 32'h0000_0000);

      // queue disabled
      write_capacity(5'd0);
      issue(CMD_PUSH, 32'h1234_5678);
      issue(CMD_JAM, 32'h1234_5678);
      issue(CMD_POP, 32'h0000_0000);
      issue(CMD_UNUSED, 32'h0000_0000);

      for (int p = 0; p < 10; p++) begin
         write_capacity(plan[p] < 0 ? CNT_W'($urandom_range(31)) : CNT_W'(plan[p]));
         idle_pct = idle_plan[p % 4];
         run_random(45);
      end

      quiesce();
      repeat (4) @(posedge clock);
      if (book.outcomes_due.size() != 0)
         book.flag($sformatf("%0d responses never arrived", book.outcomes_due.size()));
      if (book.faults == 0)
         $display("bounded_fifo_with_jam_slot regression: pass");
      else
         $display("bounded_fifo_with_jam_slot regression: fail");
      $finish;
   end

   initial begin
      #200000;
      $display("bounded_fifo_with_jam_slot regression: fail");
      $finish;
   end

endmodule

@@ bounded_fifo_with_jam_slot.f @@
design/bfj_pkg.sv
design/bfj_store.sv
design/bfj_ctrl.sv
design/bounded_fifo_with_jam_slot.sv
dv/bounded_fifo_with_jam_slot_tb.sv
